FILE: hw/rtl/tacs_pkg.sv
// ----------------------------------------------------------------------------
// tacs_pkg: shared types and constants
// Opcodes, beat layouts and sizes for the tiny accumulator cpu step block.
// ----------------------------------------------------------------------------
package tacs_pkg;

  localparam int REG_COUNT = 8;
  localparam int REG_IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam logic [7:0] REG_COUNT_B = 8'(REG_COUNT);

  localparam int MEM_DEPTH = 256;
  localparam int MEM_AW    = 8;

  localparam int PLEN_W = 17;
  localparam logic [PLEN_W-1:0] PLEN_RESET = 17'h10000;

  localparam int SIGN_BIT = 7;

  localparam logic [7:0] OP_NOP   = 8'd0;
  localparam logic [7:0] OP_HALT  = 8'd1;
  localparam logic [7:0] OP_LOADI = 8'd2;
  localparam logic [7:0] OP_LOAD  = 8'd3;
  localparam logic [7:0] OP_STORE = 8'd4;
  localparam logic [7:0] OP_ADD   = 8'd5;
  localparam logic [7:0] OP_SUB   = 8'd6;
  localparam logic [7:0] OP_JMP   = 8'd7;
  localparam logic [7:0] OP_JZ    = 8'd8;
  localparam logic [7:0] OP_JNZ   = 8'd9;
  localparam logic [7:0] OP_OUT   = 8'd10;

  // input beat, opcode in the lowest bits
  typedef struct packed {
    logic [15:0] jump_target;
    logic [7:0]  operand_byte;
    logic [7:0]  register_select;
    logic [7:0]  opcode;
  } instr_t;

  // result beat, next_pc in the lowest bits
  typedef struct packed {
    logic [1:0]  pad;
    logic        negative_flag;
    logic        carry_flag;
    logic        zero_flag;
    logic [7:0]  port_value;
    logic [7:0]  port_address;
    logic        port_write;
    logic        unknown_opcode;
    logic        halted;
    logic [15:0] next_pc;
  } result_t;

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  localparam int IN_W  = $bits(instr_t);
  localparam int OUT_W = $bits(result_t);

endpackage

FILE: hw/rtl/tacs_data_mem.sv
// ----------------------------------------------------------------------------
// tacs_data_mem: data memory
// 256-byte memory with per-entry valid bits, two registered read ports
// (operand address and address one) and write-to-read forwarding.
// ----------------------------------------------------------------------------
module tacs_data_mem (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [tacs_pkg::MEM_AW-1:0]  rd_addr,
  input  tacs_pkg::mem_wr_t            wr,
  output logic [7:0]                   rd_data,
  output logic [7:0]                   one_data
);

  localparam logic [tacs_pkg::MEM_AW-1:0] ONE_ADDR = tacs_pkg::MEM_AW'(1);

  logic [7:0]                    mem [tacs_pkg::MEM_DEPTH];
  logic [tacs_pkg::MEM_DEPTH-1:0] valid;

  logic [7:0] op_raw_q;
  logic [7:0] one_raw_q;
  logic [7:0] fwd_q;
  logic       op_hit_q;
  logic       one_hit_q;
  logic       op_valid_q;
  logic       one_valid_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      op_raw_q  <= mem[rd_addr];
      one_raw_q <= mem[ONE_ADDR];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  // a write at the read edge is not yet in the array
  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_q       <= wr.data;
      op_hit_q    <= wr.en && (wr.addr == rd_addr);
      one_hit_q   <= wr.en && (wr.addr == ONE_ADDR);
      op_valid_q  <= valid[rd_addr];
      one_valid_q <= valid[ONE_ADDR];
    end
  end

  assign rd_data  = op_hit_q  ? fwd_q : (op_valid_q  ? op_raw_q  : 8'h00);
  assign one_data = one_hit_q ? fwd_q : (one_valid_q ? one_raw_q : 8'h00);

endmodule

FILE: hw/rtl/tacs_exec.sv
// ----------------------------------------------------------------------------
// tacs_exec: instruction execute
// Holds pc, register file and flags; executes the staged instruction and
// produces the result beat and the data memory write.
// ----------------------------------------------------------------------------
module tacs_exec (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  tacs_pkg::instr_t             s_instr,
  input  logic                         fire,
  input  tacs_pkg::instr_t             instr,
  input  logic [tacs_pkg::PLEN_W-1:0]  program_length,
  input  logic [7:0]                   mem_op_data,
  input  logic [7:0]                   mem_one_data,
  output tacs_pkg::mem_wr_t            mem_wr,
  output tacs_pkg::result_t            result
);

  localparam logic [tacs_pkg::REG_IDX_W-1:0] REG_ONE = tacs_pkg::REG_IDX_W'(1);

  logic [7:0]  regs [tacs_pkg::REG_COUNT];
  logic [15:0] program_counter;
  logic        zero_bit;
  logic        carry_bit;
  logic        negative_bit;

  // register values read ahead at the accept edge
  logic [7:0] rs_data_q;
  logic [7:0] ob_data_q;

  logic [15:0] pc1, pc2, pc3, pc_next;
  logic        ok0, ok1, ok2;
  logic [7:0]  op, a, b, lo, hi;
  logic [7:0]  a_val, b_val, reg_one, load_val;
  logic        a_ok, b_ok;
  logic [8:0]  sum, diff;
  logic        reg_we;
  logic [7:0]  reg_wdata;
  logic        flags_we;
  logic [7:0]  flag_val;
  logic        flag_carry;
  logic        zero_next, carry_next, negative_next;
  logic        halted, unknown, port_write;
  logic [7:0]  port_address, port_value;

  assign reg_one = (tacs_pkg::REG_COUNT > 1) ? regs[REG_ONE] : 8'h00;

  // each fetch checked against the counter as it stands
  always_comb begin
    ok0 = {1'b0, program_counter} < program_length;
    pc1 = ok0 ? program_counter + 16'd1 : program_counter;
    ok1 = {1'b0, pc1} < program_length;
    pc2 = ok1 ? pc1 + 16'd1 : pc1;
    ok2 = {1'b0, pc2} < program_length;
    pc3 = ok2 ? pc2 + 16'd1 : pc2;
    op  = ok0 ? instr.opcode : tacs_pkg::OP_HALT;
    a   = ok1 ? instr.register_select : tacs_pkg::OP_HALT;
    b   = ok2 ? instr.operand_byte : tacs_pkg::OP_HALT;
    lo  = ok1 ? instr.jump_target[7:0] : tacs_pkg::OP_HALT;
    hi  = ok2 ? instr.jump_target[15:8] : tacs_pkg::OP_HALT;
    a_val    = ok1 ? rs_data_q : reg_one;
    b_val    = ok2 ? ob_data_q : reg_one;
    load_val = ok2 ? mem_op_data : mem_one_data;
    a_ok = a < tacs_pkg::REG_COUNT_B;
    b_ok = b < tacs_pkg::REG_COUNT_B;
    sum  = {1'b0, a_val} + {1'b0, b_val};
    diff = {1'b0, a_val} - {1'b0, b_val};
  end

  always_comb begin
    pc_next      = pc3;
    reg_we       = 1'b0;
    reg_wdata    = 8'h00;
    flags_we     = 1'b0;
    flag_val     = 8'h00;
    flag_carry   = 1'b0;
    halted       = 1'b0;
    unknown      = 1'b0;
    port_write   = 1'b0;
    port_address = 8'h00;
    port_value   = 8'h00;
    mem_wr.en    = 1'b0;
    mem_wr.addr  = b;
    mem_wr.data  = a_val;
    case (op)
      tacs_pkg::OP_NOP: begin
        pc_next = pc1;
      end
      tacs_pkg::OP_HALT: begin
        pc_next = pc1;
        halted  = 1'b1;
      end
      tacs_pkg::OP_LOADI: begin
        reg_we    = a_ok;
        reg_wdata = b;
        flags_we  = a_ok;
        flag_val  = b;
      end
      tacs_pkg::OP_LOAD: begin
        reg_we    = a_ok;
        reg_wdata = load_val;
        flags_we  = a_ok;
        flag_val  = load_val;
      end
      tacs_pkg::OP_STORE: begin
        // a stale staged store must not write again once pc has moved
        mem_wr.en = fire && a_ok;
      end
      tacs_pkg::OP_ADD: begin
        reg_we     = a_ok && b_ok;
        reg_wdata  = sum[7:0];
        flags_we   = a_ok && b_ok;
        flag_val   = sum[7:0];
        flag_carry = sum[8];
      end
      tacs_pkg::OP_SUB: begin
        reg_we     = a_ok && b_ok;
        reg_wdata  = diff[7:0];
        flags_we   = a_ok && b_ok;
        flag_val   = diff[7:0];
        flag_carry = diff[8];
      end
      tacs_pkg::OP_JMP: begin
        pc_next = {hi, lo};
      end
      tacs_pkg::OP_JZ: begin
        pc_next = zero_bit ? {hi, lo} : pc3;
      end
      tacs_pkg::OP_JNZ: begin
        pc_next = zero_bit ? pc3 : {hi, lo};
      end
      tacs_pkg::OP_OUT: begin
        port_write   = a_ok;
        port_address = a_ok ? b : 8'h00;
        port_value   = a_ok ? a_val : 8'h00;
      end
      default: begin
        pc_next = pc1;
        halted  = 1'b1;
        unknown = 1'b1;
      end
    endcase
  end

  assign zero_next     = flags_we ? (flag_val == 8'h00) : zero_bit;
  assign negative_next = flags_we ? flag_val[tacs_pkg::SIGN_BIT] : negative_bit;
  assign carry_next    = flags_we ? flag_carry : carry_bit;

  always_comb begin
    result.pad            = 2'b00;
    result.next_pc        = pc_next;
    result.halted         = halted;
    result.unknown_opcode = unknown;
    result.port_write     = port_write;
    result.port_address   = port_address;
    result.port_value     = port_value;
    result.zero_flag      = zero_next;
    result.carry_flag     = carry_next;
    result.negative_flag  = negative_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      program_counter <= 16'h0000;
      zero_bit        <= 1'b0;
      carry_bit       <= 1'b0;
      negative_bit    <= 1'b0;
      for (int i = 0; i < tacs_pkg::REG_COUNT; i++) begin
        regs[i] <= 8'h00;
      end
    end else if (fire) begin
      program_counter <= pc_next;
      zero_bit        <= zero_next;
      carry_bit       <= carry_next;
      negative_bit    <= negative_next;
      if (reg_we) begin
        regs[a[tacs_pkg::REG_IDX_W-1:0]] <= reg_wdata;
      end
    end
  end

  // read ahead for the next beat, bypassing a write at the same edge
  always_ff @(posedge clk) begin
    if (accept) begin
      if (fire && reg_we && (a == s_instr.register_select)) begin
        rs_data_q <= reg_wdata;
      end else begin
        rs_data_q <= regs[s_instr.register_select[tacs_pkg::REG_IDX_W-1:0]];
      end
      if (fire && reg_we && (a == s_instr.operand_byte)) begin
        ob_data_q <= reg_wdata;
      end else begin
        ob_data_q <= regs[s_instr.operand_byte[tacs_pkg::REG_IDX_W-1:0]];
      end
    end
  end

endmodule

FILE: hw/rtl/tiny_accumulator_cpu_step.sv
// ----------------------------------------------------------------------------
// tiny_accumulator_cpu_step: one instruction of a small 8-bit machine per beat
//
// Each s-side beat carries the opcode, the two operand bytes and the jump
// address as fetched at the current program counter. The block keeps pc,
// eight registers, a 256-byte data memory and the zero, carry and negative
// flags, and returns one m-side beat per instruction: the new pc, halt and
// unknown-opcode marks, an optional port write and the flags.
// The cfg channel writes program_length; fetches at or past it read as halt.
// It is always ready; the user must see that it is written only while the
// block is idle, which the block itself does not enforce. An accepted beat
// is staged in the input register, executed from there, and its result is
// registered and shown on m_tvalid. It takes one instruction per cycle while
// m_tready does not stall, set by the execute loop through pc, register file,
// flags and the data memory bypass. A stalled m_tready holds the result; one
// more beat is taken into the input stage, then s_tready drops.
// Reset clears pc, registers, flags, the memory valid bits (memory reads
// as zero until written) and sets program_length to 65536.
// ----------------------------------------------------------------------------
module tiny_accumulator_cpu_step (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // opcode[7:0], register_select[15:8], operand_byte[23:16], jump_target[39:24]
  input  logic [tacs_pkg::IN_W-1:0]    s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // next_pc[15:0], halted[16], unknown_opcode[17], port_write[18],
  // port_address[26:19], port_value[34:27], zero_flag[35], carry_flag[36],
  // negative_flag[37], zero fill[39:38]
  output logic [tacs_pkg::OUT_W-1:0]   m_tdata,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tacs_pkg::PLEN_W-1:0]  cfg_data
);

  tacs_pkg::instr_t          s_instr;
  tacs_pkg::instr_t          instr_q;
  logic                      in_valid;
  logic                      accept;
  logic                      fire;
  logic [tacs_pkg::PLEN_W-1:0] program_length;
  tacs_pkg::mem_wr_t         mem_wr;
  logic [7:0]                mem_op_data;
  logic [7:0]                mem_one_data;
  tacs_pkg::result_t         result;
  tacs_pkg::result_t         result_q;

  assign s_instr   = tacs_pkg::instr_t'(s_tdata);
  assign fire      = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || fire;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign m_tdata   = result_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= tacs_pkg::PLEN_RESET;
    end else if (cfg_valid) begin
      program_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      instr_q <= s_instr;
    end
  end

  tacs_data_mem u_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr  (s_instr.operand_byte),
    .wr       (mem_wr),
    .rd_data  (mem_op_data),
    .one_data (mem_one_data)
  );

  tacs_exec u_exec (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .s_instr        (s_instr),
    .fire           (fire),
    .instr          (instr_q),
    .program_length (program_length),
    .mem_op_data    (mem_op_data),
    .mem_one_data   (mem_one_data),
    .mem_wr         (mem_wr),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result_q <= result;
    end
  end

  // an unknown opcode always stops the machine
  a_unknown_halts: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && result_q.unknown_opcode |-> result_q.halted)
    else $error("unknown opcode without halt");

  // port fields are quiet unless a port is written
  a_port_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !result_q.port_write |->
      (result_q.port_address == 8'h00) && (result_q.port_value == 8'h00))
    else $error("port fields set without port write");

  // a beat taken into a full input stage must coincide with an execute
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    accept && in_valid |-> fire)
    else $error("input stage overrun");

  // a result is only produced from a staged instruction
  a_fire_from_stage: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(in_valid))
    else $error("result without staged instruction");

endmodule

FILE: verif/tiny_accumulator_cpu_step_test.sv
// ----------------------------------------------------------------------------
// tiny_accumulator_cpu_step_test: self-checking bench for the cpu step block
// Drives instruction beats at random pacing, keeps a shadow of pc, registers,
// data memory and flags, and checks every result beat against it. Runs
// directed corner cases, then random programs under several program lengths.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class cpu_shadow;
  logic [tacs_pkg::PLEN_W-1:0] prog_len;
  logic [15:0]                 pc;
  logic [15:0]                 fetch_pc;
  logic [7:0]                  regs [tacs_pkg::REG_COUNT];
  logic [7:0]                  dmem [tacs_pkg::MEM_DEPTH];
  bit                          zf, cf, nf;
  tacs_pkg::result_t           expected_steps [$];
  int                          errors, steps_seen, instrs_taken, halts, port_writes;

  function new();
    prog_len = tacs_pkg::PLEN_RESET;
    pc = '0;
    foreach (regs[i]) regs[i] = '0;
    foreach (dmem[i]) dmem[i] = '0;
    zf = 1'b0;
    cf = 1'b0;
    nf = 1'b0;
    errors = 0;
    steps_seen = 0;
    instrs_taken = 0;
    halts = 0;
    port_writes = 0;
  endfunction

  function void set_length(logic [tacs_pkg::PLEN_W-1:0] len);
    prog_len = len;
  endfunction

  // bytes at or past the program end read as halt and leave the pc alone
  function logic [7:0] fetch(logic [7:0] b);
    if ({1'b0, fetch_pc} >= prog_len) return tacs_pkg::OP_HALT;
    fetch_pc = fetch_pc + 16'd1;
    return b;
  endfunction

  function void load_flags(logic [7:0] v, bit carry);
    zf = (v == 8'h00);
    nf = v[tacs_pkg::SIGN_BIT];
    cf = carry;
  endfunction

  function void accept_instr(tacs_pkg::instr_t ins);
    tacs_pkg::result_t r;
    logic [7:0]        op, a, b, lo, hi;
    logic [8:0]        sum;
    r = '0;
    fetch_pc = pc;
    op = fetch(ins.opcode);
    if (op == tacs_pkg::OP_NOP) begin
    end else if (op == tacs_pkg::OP_HALT) begin
      r.halted = 1'b1;
    end else if (op <= tacs_pkg::OP_SUB || op == tacs_pkg::OP_OUT) begin
      a = fetch(ins.register_select);
      b = fetch(ins.operand_byte);
      if (a < tacs_pkg::REG_COUNT_B) begin
        case (op)
          tacs_pkg::OP_LOADI: begin
            regs[a] = b;
            load_flags(b, 1'b0);
          end
          tacs_pkg::OP_LOAD: begin
            regs[a] = dmem[b];
            load_flags(dmem[b], 1'b0);
          end
          tacs_pkg::OP_STORE: dmem[b] = regs[a];
          tacs_pkg::OP_ADD: if (b < tacs_pkg::REG_COUNT_B) begin
            sum = {1'b0, regs[a]} + {1'b0, regs[b]};
            regs[a] = sum[7:0];
            load_flags(sum[7:0], sum[8]);
          end
          tacs_pkg::OP_SUB: if (b < tacs_pkg::REG_COUNT_B) begin
            // bit 8 of the wide difference is the borrow
            sum = {1'b0, regs[a]} - {1'b0, regs[b]};
            regs[a] = sum[7:0];
            load_flags(sum[7:0], sum[8]);
          end
          default: begin
            r.port_write = 1'b1;
            r.port_address = b;
            r.port_value = regs[a];
          end
        endcase
      end
    end else if (op <= tacs_pkg::OP_JNZ) begin
      lo = fetch(ins.jump_target[7:0]);
      hi = fetch(ins.jump_target[15:8]);
      if (op == tacs_pkg::OP_JMP || (op == tacs_pkg::OP_JZ && zf) ||
          (op == tacs_pkg::OP_JNZ && !zf)) fetch_pc = {hi, lo};
    end else begin
      r.halted = 1'b1;
      r.unknown_opcode = 1'b1;
    end
    pc = fetch_pc;
    r.next_pc = pc;
    r.zero_flag = zf;
    r.carry_flag = cf;
    r.negative_flag = nf;
    instrs_taken++;
    if (r.halted) halts++;
    if (r.port_write) port_writes++;
    expected_steps.push_back(r);
  endfunction

  task report(string what, logic [15:0] want, logic [15:0] got);
    errors++;
    if (errors <= 100) $display("step %0d: %s expected %h got %h", steps_seen, what, want, got);
  endtask

  task check_step(tacs_pkg::result_t got);
    tacs_pkg::result_t want;
    steps_seen++;
    if (expected_steps.size() == 0) begin
      report("beat with nothing pending, next_pc", 'x, got.next_pc);
    end else begin
      want = expected_steps.pop_front();
      if (got.next_pc !== want.next_pc) report("next_pc", want.next_pc, got.next_pc);
      if (got.halted !== want.halted)
        report("halted", 16'(want.halted), 16'(got.halted));
      if (got.unknown_opcode !== want.unknown_opcode)
        report("unknown_opcode", 16'(want.unknown_opcode), 16'(got.unknown_opcode));
      if (got.port_write !== want.port_write)
        report("port_write", 16'(want.port_write), 16'(got.port_write));
      if (got.port_address !== want.port_address)
        report("port_address", 16'(want.port_address), 16'(got.port_address));
      if (got.port_value !== want.port_value)
        report("port_value", 16'(want.port_value), 16'(got.port_value));
      if (got.zero_flag !== want.zero_flag)
        report("zero_flag", 16'(want.zero_flag), 16'(got.zero_flag));
      if (got.carry_flag !== want.carry_flag)
        report("carry_flag", 16'(want.carry_flag), 16'(got.carry_flag));
      if (got.negative_flag !== want.negative_flag)
        report("negative_flag", 16'(want.negative_flag), 16'(got.negative_flag));
    end
  endtask
endclass

module tiny_accumulator_cpu_step_test;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [tacs_pkg::IN_W-1:0]   s_tdata = '0;
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [tacs_pkg::OUT_W-1:0]  m_tdata;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [tacs_pkg::PLEN_W-1:0] cfg_data = '0;

  cpu_shadow sb;
  int        send_pct = 0;
  int        recv_pct = 0;
  int        stall_cycles = 0;
  int        lengths_written = 0;

  tiny_accumulator_cpu_step uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result side: random back-pressure, checking and the stall counter
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_cycles <= 0;
    end else begin
      if (m_tvalid && m_tready) sb.check_step(tacs_pkg::result_t'(m_tdata));
      m_tready <= ($urandom_range(0, 99) >= recv_pct);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic tacs_pkg::instr_t make_instr(logic [7:0] op, logic [7:0] rsel,
                                                  logic [7:0] obyte,
                                                  logic [15:0] target = 16'h0000);
    tacs_pkg::instr_t ins;
    ins.opcode = op;
    ins.register_select = rsel;
    ins.operand_byte = obyte;
    ins.jump_target = target;
    return ins;
  endfunction

  // mostly well-formed instructions, some bad registers and raw noise
  function automatic tacs_pkg::instr_t random_instr();
    tacs_pkg::instr_t ins;
    int unsigned      roll;
    roll = $urandom_range(0, 99);
    ins.jump_target = 16'($urandom);
    ins.operand_byte = 8'($urandom);
    ins.register_select = 8'($urandom_range(0, tacs_pkg::REG_COUNT - 1));
    if (roll < 10) begin
      ins.opcode = 8'($urandom);
      ins.register_select = 8'($urandom);
    end else begin
      ins.opcode = 8'($urandom_range(0, tacs_pkg::OP_OUT));
      if (roll < 16) ins.register_select = 8'($urandom);
      if ((ins.opcode == tacs_pkg::OP_ADD || ins.opcode == tacs_pkg::OP_SUB) && roll < 85)
        ins.operand_byte = 8'($urandom_range(0, tacs_pkg::REG_COUNT - 1));
      if ((ins.opcode == tacs_pkg::OP_LOAD || ins.opcode == tacs_pkg::OP_STORE) && roll < 60)
        ins.operand_byte = 8'($urandom_range(0, 15));
      if (ins.opcode == tacs_pkg::OP_LOADI && roll < 40) begin
        case ($urandom_range(0, 3))
          0: ins.operand_byte = 8'h00;
          1: ins.operand_byte = 8'h7f;
          2: ins.operand_byte = 8'h80;
          default: ins.operand_byte = 8'hff;
        endcase
      end
    end
    return ins;
  endfunction

  // leaves tvalid high after the beat; the next call or a drain decides its level
  task send_instr(tacs_pkg::instr_t ins);
    while ($urandom_range(0, 99) < send_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= ins;
    do @(posedge clk); while (!s_tready);
    sb.accept_instr(ins);
  endtask

  task send_random(int count);
    repeat (count) send_instr(random_instr());
  endtask

  task wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.expected_steps.size() != 0);
  endtask

  task write_length(logic [tacs_pkg::PLEN_W-1:0] len);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_length(len);
    lengths_written++;
  endtask

  task run_phase(int sp, int rp, int count);
    logic [tacs_pkg::PLEN_W-1:0] len;
    send_pct = sp;
    recv_pct = rp;
    write_length(tacs_pkg::PLEN_RESET);
    send_random(count * 2 / 5);
    // program end a few bytes past the pc: operands fall off the end
    len = tacs_pkg::PLEN_W'(sb.pc) + tacs_pkg::PLEN_W'($urandom_range(1, 3));
    if (len > tacs_pkg::PLEN_RESET) len = tacs_pkg::PLEN_RESET;
    write_length(len);
    send_random(8);
    write_length(tacs_pkg::PLEN_W'($urandom_range(0, 65536)));
    send_random(count / 10);
    write_length(tacs_pkg::PLEN_RESET);
    send_random(count / 5);
    wait_drained();
    send_random(count / 5);
    write_length('0);
    send_random(6);
    write_length(tacs_pkg::PLEN_W'(65535));
    send_random(count / 10);
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    send_pct = 32;
    recv_pct = 77;

    // flags from loads, add carry, sub borrow, conditional jumps
    send_instr(make_instr(tacs_pkg::OP_NOP, 8'h00, 8'h00));
    send_instr(make_instr(tacs_pkg::OP_LOADI, 8'h00, 8'hff));
    send_instr(make_instr(tacs_pkg::OP_LOADI, 8'h01, 8'h01));
    send_instr(make_instr(tacs_pkg::OP_ADD, 8'h00, 8'h01));
    send_instr(make_instr(tacs_pkg::OP_JZ, 8'h40, 8'h00, 16'h0040));
    send_instr(make_instr(tacs_pkg::OP_JNZ, 8'h11, 8'h11, 16'h1111));
    send_instr(make_instr(tacs_pkg::OP_SUB, 8'h00, 8'h01));
    send_instr(make_instr(tacs_pkg::OP_SUB, 8'h01, 8'h00));
    // memory and port traffic, including an address never stored
    send_instr(make_instr(tacs_pkg::OP_LOADI, 8'h07, 8'h80));
    send_instr(make_instr(tacs_pkg::OP_STORE, 8'h07, 8'hff));
    send_instr(make_instr(tacs_pkg::OP_LOAD, 8'h02, 8'hff));
    send_instr(make_instr(tacs_pkg::OP_LOAD, 8'h03, 8'h00));
    send_instr(make_instr(tacs_pkg::OP_OUT, 8'h07, 8'hff));
    // out-of-range registers only move the pc
    send_instr(make_instr(tacs_pkg::OP_OUT, 8'h08, 8'h12));
    send_instr(make_instr(tacs_pkg::OP_LOADI, 8'hff, 8'h01));
    send_instr(make_instr(tacs_pkg::OP_ADD, 8'h00, 8'hc8));
    // pc wrap at the top of the address space
    send_instr(make_instr(tacs_pkg::OP_JMP, 8'hfe, 8'hff, 16'hfffe));
    send_instr(make_instr(tacs_pkg::OP_NOP, 8'h00, 8'h00));
    send_instr(make_instr(tacs_pkg::OP_NOP, 8'h00, 8'h00));
    send_instr(make_instr(tacs_pkg::OP_JMP, 8'hff, 8'hff, 16'hffff));
    send_instr(make_instr(tacs_pkg::OP_LOADI, 8'h05, 8'h7f));
    // halt and unknown opcodes, then normal execution resumes
    send_instr(make_instr(tacs_pkg::OP_HALT, 8'h00, 8'h00));
    send_instr(make_instr(8'h0b, 8'h00, 8'h00));
    send_instr(make_instr(8'hff, 8'hff, 8'hff, 16'hffff));
    // fetches past the program end
    write_length(tacs_pkg::PLEN_W'(sb.pc) + tacs_pkg::PLEN_W'(1));
    send_instr(make_instr(tacs_pkg::OP_LOADI, 8'h00, 8'h55));
    send_instr(make_instr(tacs_pkg::OP_STORE, 8'h00, 8'h00));
    write_length(tacs_pkg::PLEN_W'(sb.pc) + tacs_pkg::PLEN_W'(2));
    send_instr(make_instr(tacs_pkg::OP_JMP, 8'h34, 8'h12, 16'h1234));

    run_phase(32, 77, 230);
    run_phase(77, 32, 230);
    run_phase(0, 0, 230);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("executed %0d instructions (%0d halts, %0d port writes) over %0d length writes",
             sb.instrs_taken, sb.halts, sb.port_writes, lengths_written);
    $display("checked %0d result beats, %0d mismatches", sb.steps_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/tacs_pkg.sv
hw/rtl/tacs_data_mem.sv
hw/rtl/tacs_exec.sv
hw/rtl/tiny_accumulator_cpu_step.sv
verif/tiny_accumulator_cpu_step_test.sv
